// File: rtl/hrie_pkg.sv
// shared constants, codes and the job type for the input-report decoder
// no dependencies
package hrie_pkg;

  localparam int unsigned NumKeys    = 6;
  localparam int unsigned NumBytes   = 7;  // message bytes 2 to 8
  localparam int unsigned MaskW      = 6;  // at most six events per message
  localparam int unsigned NumButtons = 3;
  localparam int unsigned IdxW       = $clog2(MaskW);

  localparam logic [7:0] CmdInput       = 8'd3;
  localparam logic [7:0] FuncTouch      = 8'd0;
  localparam logic [7:0] FuncMouse      = 8'd2;
  localparam logic [7:0] FuncKeyboard   = 8'd3;
  localparam logic [7:0] MinLenAny      = 8'd4;
  localparam logic [7:0] MinLenTouch    = 8'd8;
  localparam logic [7:0] MinLenMouse    = 8'd7;
  localparam logic [7:0] MinLenKeyboard = 8'd9;

  localparam logic [1:0] KindTouch  = 2'd0;
  localparam logic [1:0] KindMove   = 2'd1;
  localparam logic [1:0] KindButton = 2'd2;
  localparam logic [1:0] KindKey    = 2'd3;

  typedef enum logic [1:0] {
    ModeTouch,
    ModeMouse,
    ModeKey
  } mode_e;

  // one decoded message: raw bytes 2..8 and the set of events still to send
  typedef struct packed {
    mode_e                        mode;
    logic [NumBytes-1:0][7:0]     bytes;
    logic [MaskW-1:0]             mask;
  } job_t;

endpackage

// File: rtl/hrie_front.sv
// front end: checks and classifies each message, diffs it against the stored
// buttons and keys and hands a job to the queue; uses hrie_pkg
module hrie_front import hrie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] msg_len_i,
  input  logic       is_sysex_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [7:0] func_byte_i,
  input  logic [NumBytes-1:0][7:0] bytes_i,
  input  logic       q_ready_i,
  output logic       q_valid_o,
  output job_t       q_job_o
);

  logic [7:0]               prev_buttons_q, prev_buttons_d;
  logic [NumKeys-1:0][7:0]  prev_keys_q, prev_keys_d;
  logic                     accept;
  logic                     head_ok, is_touch, is_mouse, is_key;
  logic                     move, seen;
  logic [7:0]               changed, key;
  logic [MaskW-1:0]         mask;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  always_comb begin
    head_ok  = is_sysex_i && (msg_len_i >= MinLenAny) && (cmd_byte_i == CmdInput);
    is_touch = head_ok && (func_byte_i == FuncTouch) && (msg_len_i >= MinLenTouch);
    is_mouse = head_ok && (func_byte_i == FuncMouse) && (msg_len_i >= MinLenMouse);
    is_key   = head_ok && (func_byte_i == FuncKeyboard) && (msg_len_i >= MinLenKeyboard);

    move    = ({bytes_i[1], bytes_i[2], bytes_i[3], bytes_i[4]} != 32'd0);
    changed = bytes_i[0] ^ prev_buttons_q;

    key  = 8'd0;
    seen = 1'b0;
    mask = '0;
    q_job_o.mode = ModeTouch;
    if (is_touch) begin
      mask[0] = 1'b1;
    end else if (is_mouse) begin
      q_job_o.mode = ModeMouse;
      mask[0] = move;
      mask[NumButtons:1] = changed[NumButtons-1:0];
    end else if (is_key) begin
      q_job_o.mode = ModeKey;
      for (int i = 0; i < NumKeys; i++) begin
        key  = bytes_i[i+1];
        seen = 1'b0;
        for (int j = 0; j < NumKeys; j++) begin
          if (prev_keys_q[j] == key) seen = 1'b1;
        end
        mask[i] = (key != 8'd0) && !seen;
      end
    end
    q_job_o.bytes = bytes_i;
    q_job_o.mask  = mask;
    q_valid_o     = in_valid_i && (mask != '0);

    prev_buttons_d = prev_buttons_q;
    prev_keys_d    = prev_keys_q;
    if (accept && is_mouse) prev_buttons_d = bytes_i[0];
    if (accept && is_key) begin
      for (int i = 0; i < NumKeys; i++) prev_keys_d[i] = bytes_i[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_buttons_q <= '0;
      prev_keys_q    <= '0;
    end else begin
      prev_buttons_q <= prev_buttons_d;
      prev_keys_q    <= prev_keys_d;
    end
  end

endmodule

// File: rtl/hrie_queue.sv
// two-entry job queue between front and back end; uses hrie_pkg
module hrie_queue import hrie_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_job_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_job_o
);

  job_t        slot_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_job_o   = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= wr_job_i;
  end

endmodule

// File: rtl/hrie_back.sv
// back end: walks the event set of the current job, one event per cycle
// while out_ready_i allows, into an output register; uses hrie_pkg
module hrie_back import hrie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  job_t               q_job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic [7:0]         touch_phase_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic [7:0]         ident_o,
  output logic [7:0]         flag_bits_o,
  output logic               last_of_run_o
);

  job_t              cur_q, cur_d;
  logic [MaskW-1:0]  mask_q, mask_d, rest, mask_after;
  logic [IdxW-1:0]   idx;
  logic [1:0]        btn;
  logic              advance, emit, load;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        kind_q, kind_d;
  logic [7:0]        phase_q, phase_d, ident_q, ident_d, flags_q, flags_d;
  logic [15:0]       x_q, x_d, y_q, y_d;
  logic              last_q, last_d;

  always_comb begin
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (mask_q[i]) idx = IdxW'(i);
    end
    rest       = mask_q & ~(MaskW'(1) << idx);
    advance    = !out_valid_q || out_ready_i;
    emit       = advance && (mask_q != '0);
    mask_after = emit ? rest : mask_q;
    load       = (mask_after == '0) && q_valid_i;
    q_ready_o  = load;
    mask_d     = load ? q_job_i.mask : mask_after;
    cur_d      = load ? q_job_i : cur_q;
    btn        = 2'(idx - IdxW'(1));

    kind_d  = kind_q;
    phase_d = phase_q;
    x_d     = x_q;
    y_d     = y_q;
    ident_d = ident_q;
    flags_d = flags_q;
    last_d  = last_q;
    out_valid_d = advance ? emit : out_valid_q;
    if (emit) begin
      last_d  = (rest == '0);
      phase_d = 8'd0;
      x_d     = 16'd0;
      y_d     = 16'd0;
      ident_d = 8'd0;
      flags_d = 8'd0;
      unique case (cur_q.mode)
        ModeTouch: begin
          kind_d  = KindTouch;
          phase_d = cur_q.bytes[0];
          x_d     = {cur_q.bytes[1], cur_q.bytes[2]};
          y_d     = {cur_q.bytes[3], cur_q.bytes[4]};
          ident_d = cur_q.bytes[5];
        end
        ModeMouse: begin
          if (idx == '0) begin
            kind_d  = KindMove;
            x_d     = {cur_q.bytes[1], cur_q.bytes[2]};
            y_d     = {cur_q.bytes[3], cur_q.bytes[4]};
            flags_d = cur_q.bytes[0];
          end else begin
            kind_d  = KindButton;
            ident_d = {6'd0, btn};
            flags_d = {7'd0, cur_q.bytes[0][btn]};
          end
        end
        ModeKey: begin
          kind_d  = KindKey;
          ident_d = cur_q.bytes[idx + IdxW'(1)];
          flags_d = cur_q.bytes[0];
        end
        default: begin
          kind_d = KindTouch;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    kind_q  <= kind_d;
    phase_q <= phase_d;
    x_q     <= x_d;
    y_q     <= y_d;
    ident_q <= ident_d;
    flags_q <= flags_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign touch_phase_o = phase_q;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;
  assign ident_o       = ident_q;
  assign flag_bits_o   = flags_q;
  assign last_of_run_o = last_q;

endmodule

// File: rtl/hid_report_to_input_events.sv
// top level of the input-report decoder: front end, job queue, back end
// depends on hrie_pkg, hrie_front, hrie_queue, hrie_back
//
// usage
//   input channel: one item per message (length, sysex flag, command,
//   function, bytes 2..8) under in_valid_i / in_ready_o
//   output channel: one item per event under out_valid_o / out_ready_i;
//   last_of_run_o marks the final event of a message
// path: the first event of a message goes through the queue slot, the job
//   load in the back end and the output register before it shows on the
//   outputs; the queue write happens at the accepting edge itself
// throughput: the back end sends one event per cycle while out_ready_i
//   allows; a message makes one to six events, and messages that make no
//   event are accepted but not queued; the front end takes a new message
//   every cycle while the two-entry queue has room
// stall: when the receiver holds out_ready_i low the output register holds,
//   the back end stops, the queue fills and then in_ready_o drops
// reset: clears the stored mouse buttons and keyboard keys to zero, empties
//   the queue and drops out_valid_o
module hid_report_to_input_events import hrie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // message channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         msg_len_i,
  input  logic               is_sysex_i,
  input  logic [7:0]         cmd_byte_i,
  input  logic [7:0]         func_byte_i,
  input  logic [7:0]         byte2_i,
  input  logic [7:0]         byte3_i,
  input  logic [7:0]         byte4_i,
  input  logic [7:0]         byte5_i,
  input  logic [7:0]         byte6_i,
  input  logic [7:0]         byte7_i,
  input  logic [7:0]         byte8_i,
  // event channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_kind_o,
  output logic [7:0]         touch_phase_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic [7:0]         ident_o,
  output logic [7:0]         flag_bits_o,
  output logic               last_of_run_o
);

  logic [NumBytes-1:0][7:0] bytes;
  // front to queue
  logic fq_valid, fq_ready;
  job_t fq_job;
  // queue to back
  logic qb_valid, qb_ready;
  job_t qb_job;

  // bytes 2..8 packed low to high
  assign bytes = {byte8_i, byte7_i, byte6_i, byte5_i, byte4_i, byte3_i, byte2_i};

  // classify and diff against stored buttons and keys
  hrie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .msg_len_i   (msg_len_i),
    .is_sysex_i  (is_sysex_i),
    .cmd_byte_i  (cmd_byte_i),
    .func_byte_i (func_byte_i),
    .bytes_i     (bytes),
    .q_ready_i   (fq_ready),
    .q_valid_o   (fq_valid),
    .q_job_o     (fq_job)
  );

  // decouples the front end from a stalled back end
  hrie_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_job_i   (fq_job),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_job_o   (qb_job)
  );

  // sends the events of each job in order
  hrie_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (qb_valid),
    .q_ready_o     (qb_ready),
    .q_job_i       (qb_job),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .touch_phase_o (touch_phase_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .ident_o       (ident_o),
    .flag_bits_o   (flag_bits_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
